// ===== rtl/core/pcp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types, sizes and helpers of the photon coincidence pairer.
// ----------------------------------------------------------------------------
package pcp_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int REGION_COUNT = 8;
   localparam int TIME_BITS    = 48;
   localparam int MAX_PAIRS    = 16;

   localparam int REGION_W = 3;
   localparam int WIN_W    = 24;
   localparam int MASK_W   = 64;
   localparam int CNT_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int NPAIR_W  = $clog2(MAX_PAIRS + 1);
   localparam int LIMIT_W  = WIN_W + 1;
   localparam int CMP_W    = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COINC_WINDOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNORDER_MARGIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_PAIRS  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_STORE
   } state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] tstamp;
      logic [REGION_W-1:0]  region;
   } entry_type;

   // outcome of one comparison of the new photon with a stored one
   typedef struct packed {
      logic close;
      logic reject;
      logic pair;
      logic old_first;
   } cmp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] first_time;
      logic [REGION_W-1:0]  first_region;
      logic [TIME_BITS-1:0] second_time;
      logic [REGION_W-1:0]  second_region;
      logic [CNT_W-1:0]     prompt;
      logic [CNT_W-1:0]     region_rej;
      logic [CNT_W-1:0]     time_rej;
   } pair_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
   endfunction

   // physical slot of the k-th oldest entry in the ring
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] k);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, k};
      if (sum >= (IDX_W+1)'(WINDOW_DEPTH)) begin
         sum = sum - (IDX_W+1)'(WINDOW_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== rtl/core/pcp_compare.sv =====
// ----------------------------------------------------------------------------
// pcp_compare
// Compare unit: classifies one stored photon against the new photon.
// ----------------------------------------------------------------------------
module pcp_compare (
   input  logic [pcp_pkg::TIME_BITS-1:0] t_new,
   input  logic [pcp_pkg::REGION_W-1:0]  r_new,
   input  logic [pcp_pkg::TIME_BITS-1:0] t_old,
   input  logic [pcp_pkg::REGION_W-1:0]  r_old,
   input  logic [pcp_pkg::WIN_W-1:0]     coinc_window,
   input  logic [pcp_pkg::LIMIT_W-1:0]   close_limit,
   input  logic [pcp_pkg::MASK_W-1:0]    allowed_pairs,
   output pcp_pkg::cmp_type              result
);
   import pcp_pkg::*;

   logic                 new_later;
   logic [TIME_BITS-1:0] diff_fwd;
   logic [TIME_BITS-1:0] diff_bwd;
   logic [TIME_BITS-1:0] diff;
   logic                 region_ok;

   assign new_later = t_new > t_old;
   assign diff_fwd  = t_new - t_old;
   assign diff_bwd  = t_old - t_new;
   assign diff      = new_later ? diff_fwd : diff_bwd;

   assign region_ok = ({1'b0, r_old} < (REGION_W+1)'(REGION_COUNT))
                   && ({1'b0, r_new} < (REGION_W+1)'(REGION_COUNT))
                   && allowed_pairs[{r_old, r_new}];

   always_comb begin
      result.close     = new_later && (CMP_W'(diff) > CMP_W'(close_limit));
      result.reject    = !result.close && !region_ok;
      result.pair      = !result.close && region_ok
                      && (CMP_W'(diff) <= CMP_W'(coinc_window));
      result.old_first = r_old > r_new;
   end

endmodule

// ===== rtl/core/photon_coincidence_pairer.sv =====
// ----------------------------------------------------------------------------
// photon_coincidence_pairer
// Coincidence window sorter: pairs each new photon with open stored photons.
// ----------------------------------------------------------------------------
// Photons enter on the req_ channel (time, region, frame_end); a transfer
// happens when req_valid is high and req_stall is low. Pairs leave on the
// rsp_ channel, higher region first, with the three saturating counters
// as they stood just after the comparison that made the pair; last_of_run
// marks the last pair caused by one photon. csr_ writes set the window,
// the unorder margin and the region matrix; the user must write them only
// while the block is idle, as the block itself does not enforce it.
// For each photon the block takes it, then reads and compares each stored
// entry of the window (at most 16) through the single compare unit,
// then stores it. A pair is held back until the next pair or the end of
// the scan, and only then moves into the output register. When rsp_stall
// holds a pair in the output register while another pair is held back,
// the scan waits at the next pair found; req_stall stays high until the
// photon is stored. Reset empties the window, clears the counters and
// loads the register reset values; the stored times need no clearing pass.
// ----------------------------------------------------------------------------
module photon_coincidence_pairer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pcp_pkg::TIME_BITS-1:0]  req_photon_time,
   input  logic [pcp_pkg::REGION_W-1:0]   req_photon_region,
   input  logic                           req_frame_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pcp_pkg::TIME_BITS-1:0]  rsp_first_time,
   output logic [pcp_pkg::REGION_W-1:0]   rsp_first_region,
   output logic [pcp_pkg::TIME_BITS-1:0]  rsp_second_time,
   output logic [pcp_pkg::REGION_W-1:0]   rsp_second_region,
   output logic                           rsp_last_of_run,
   output logic [pcp_pkg::CNT_W-1:0]      rsp_prompt_total,
   output logic [pcp_pkg::CNT_W-1:0]      rsp_region_reject_total,
   output logic [pcp_pkg::CNT_W-1:0]      rsp_time_reject_total,
   input  logic                           csr_we,
   input  logic [pcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcp_pkg::MASK_W-1:0]     csr_wdata
);
   import pcp_pkg::*;

   // configuration
   logic [WIN_W-1:0]  coinc_window_ff;
   logic [WIN_W-1:0]  unorder_margin_ff;
   logic [MASK_W-1:0] allowed_pairs_ff;
   logic [LIMIT_W-1:0] close_limit;

   // sequencer and window
   state_type          state_ff, state_in;
   entry_type          mem [WINDOW_DEPTH];
   entry_type          rd_data_ff;
   logic [WINDOW_DEPTH-1:0] open_ff, open_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]   cur_slot_ff, cur_slot_in;
   logic [NPAIR_W-1:0] npair_ff, npair_in;
   entry_type          new_ff, new_in;
   logic               frame_end_ff, frame_end_in;

   // counters
   logic [CNT_W-1:0]   prompt_ff, prompt_in;
   logic [CNT_W-1:0]   rrej_ff, rrej_in;
   logic [CNT_W-1:0]   trej_ff, trej_in;

   // held pair and output register
   logic               pend_valid_ff, pend_valid_in;
   pair_type           pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff, rsp_last_in;
   pair_type           rsp_ff, rsp_in;

   cmp_type            cmp;
   logic               active;
   logic               emit;
   logic               out_free;
   logic               cmp_wait;
   logic               store_wait;
   logic               last_entry;
   logic               mem_we;
   logic [IDX_W-1:0]   wr_slot;
   logic [IDX_W-1:0]   rd_slot;

   assign close_limit = {1'b0, coinc_window_ff} + {1'b0, unorder_margin_ff};

   pcp_compare u_compare (
      .t_new         (new_ff.tstamp),
      .r_new         (new_ff.region),
      .t_old         (rd_data_ff.tstamp),
      .r_old         (rd_data_ff.region),
      .coinc_window  (coinc_window_ff),
      .close_limit   (close_limit),
      .allowed_pairs (allowed_pairs_ff),
      .result        (cmp)
   );

   assign active     = open_ff[cur_slot_ff];
   assign emit       = active && cmp.pair && (npair_ff < NPAIR_W'(MAX_PAIRS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cmp_wait   = emit && pend_valid_ff && !out_free;
   assign store_wait = pend_valid_ff && !out_free;
   assign last_entry = (k_ff + FILL_W'(1)) >= fill_ff;
   assign rd_slot    = slot_of(head_ff, k_ff[IDX_W-1:0]);
   assign wr_slot    = (fill_ff == FILL_W'(WINDOW_DEPTH)) ? head_ff
                     : slot_of(head_ff, fill_ff[IDX_W-1:0]);
   assign mem_we     = (state_ff == ST_STORE) && !store_wait;

   assign req_stall = state_ff != ST_IDLE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (fill_ff == '0) ? ST_STORE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!cmp_wait) begin
               state_in = last_entry ? ST_STORE : ST_READ;
            end
         end
         ST_STORE: begin
            if (!store_wait) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin
      open_in       = open_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      cur_slot_in   = cur_slot_ff;
      npair_in      = npair_ff;
      new_in        = new_ff;
      frame_end_in  = frame_end_ff;
      prompt_in     = prompt_ff;
      rrej_in       = rrej_ff;
      trej_in       = trej_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               new_in.tstamp = req_photon_time;
               new_in.region = req_photon_region;
               frame_end_in  = req_frame_end;
               k_in          = '0;
               npair_in      = '0;
            end
         end
         ST_READ: begin
            cur_slot_in = rd_slot;
         end
         ST_CMP: begin
            if (!cmp_wait) begin
               k_in = k_ff + FILL_W'(1);
               if (active) begin
                  if (cmp.close) begin
                     open_in[cur_slot_ff] = 1'b0;
                     trej_in = sat_inc(trej_ff);
                  end else if (cmp.reject) begin
                     rrej_in = sat_inc(rrej_ff);
                  end else if (cmp.pair) begin
                     prompt_in = sat_inc(prompt_ff);
                  end
               end
               if (emit) begin
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  pend_valid_in         = 1'b1;
                  npair_in              = npair_ff + NPAIR_W'(1);
                  pend_in.first_time    = cmp.old_first ? rd_data_ff.tstamp : new_ff.tstamp;
                  pend_in.first_region  = cmp.old_first ? rd_data_ff.region : new_ff.region;
                  pend_in.second_time   = cmp.old_first ? new_ff.tstamp : rd_data_ff.tstamp;
                  pend_in.second_region = cmp.old_first ? new_ff.region : rd_data_ff.region;
                  pend_in.prompt        = prompt_in;
                  pend_in.region_rej    = rrej_in;
                  pend_in.time_rej      = trej_in;
               end
            end
         end
         ST_STORE: begin
            if (!store_wait) begin
               if (pend_valid_ff) begin
                  rsp_in        = pend_ff;
                  rsp_last_in   = 1'b1;
                  rsp_valid_in  = 1'b1;
                  pend_valid_in = 1'b0;
               end
               if (fill_ff == FILL_W'(WINDOW_DEPTH)) begin
                  head_in = slot_of(head_ff, IDX_W'(1));
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               open_in[wr_slot] = 1'b1;
               if (frame_end_ff) begin
                  open_in = '0;
                  fill_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coinc_window_ff   <= '0;
         unorder_margin_ff <= '0;
         allowed_pairs_ff  <= '1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COINC_WINDOW:   coinc_window_ff   <= csr_wdata[WIN_W-1:0];
            CSR_UNORDER_MARGIN: unorder_margin_ff <= csr_wdata[WIN_W-1:0];
            CSR_ALLOWED_PAIRS:  allowed_pairs_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // window storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_slot] <= new_ff;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         open_ff       <= '0;
         head_ff       <= '0;
         fill_ff       <= '0;
         k_ff          <= '0;
         cur_slot_ff   <= '0;
         npair_ff      <= '0;
         prompt_ff     <= '0;
         rrej_ff       <= '0;
         trej_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_ff       <= open_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         k_ff          <= k_in;
         cur_slot_ff   <= cur_slot_in;
         npair_ff      <= npair_in;
         prompt_ff     <= prompt_in;
         rrej_ff       <= rrej_in;
         trej_ff       <= trej_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff       <= new_in;
      frame_end_ff <= frame_end_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_first_time          = rsp_ff.first_time;
   assign rsp_first_region        = rsp_ff.first_region;
   assign rsp_second_time         = rsp_ff.second_time;
   assign rsp_second_region       = rsp_ff.second_region;
   assign rsp_last_of_run         = rsp_last_ff;
   assign rsp_prompt_total        = rsp_ff.prompt;
   assign rsp_region_reject_total = rsp_ff.region_rej;
   assign rsp_time_reject_total   = rsp_ff.time_rej;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_DEPTH))
      else $error("window fill beyond depth");

   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held pair left over after a photon was stored");

   a_prompt_mono: assert property (@(posedge clock) disable iff (reset)
      prompt_ff >= $past(prompt_ff))
      else $error("prompt counter went backwards");

   a_pair_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (npair_ff <= NPAIR_W'(MAX_PAIRS)))
      else $error("pair count beyond limit");
`endif

endmodule
